// ===== hw/rtl/pcl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcl_pkg - shared constants, types and helpers of the clamped-integral PID
// Fixed-point formats, register indexes, sequencer states, saturation helpers.
// ----------------------------------------------------------------------------
package pcl_pkg;

  // fixed-point format
  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;

  // word field widths (fixed by the interface)
  localparam int FIELD_W = 32;
  localparam int DT_W    = 31;
  localparam int LIM_W   = 31;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  localparam int LIMIT_INT = 200;
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(LIMIT_INT << FRAC_BITS);

  // multiplier operand width: magnitudes of any state value or gain
  localparam int MW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
  localparam int PW = 2 * MW;

  // divider: (|diff| << FRAC_BITS), padded to an even count, two bits per cycle
  localparam int NW        = DATA_WIDTH + 1 + FRAC_BITS;
  localparam int NWP       = NW + (NW % 2);
  localparam int DIV_STEPS = NWP / 2;
  localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // gain terms clamp to 62 bit signed, three of them sum into 64 bits
  localparam int TERM_K = 61;
  localparam int ACC_W  = 64;
  localparam int TW     = (PW > TERM_K + 2) ? PW : TERM_K + 2;
  localparam int SW     = (PW > NWP) ? PW : NWP;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SETPOINT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_GAIN_P   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_GAIN_I   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_GAIN_D   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_LIMIT    = IDX_W'(4);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIFF,
    ST_INTG,
    ST_MUL_I,
    ST_ACC_I,
    ST_DIVW,
    ST_MUL_D,
    ST_ACC_D,
    ST_OUT
  } pcl_state_t;

  // magnitude m with sign neg, clamped to the DATA_WIDTH signed range
  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(logic [SW-1:0] m, logic neg);
    logic [SW-1:0] cap;
    logic [SW-1:0] v;
    cap = neg ? (SW'(1) << (DATA_WIDTH - 1)) : ((SW'(1) << (DATA_WIDTH - 1)) - SW'(1));
    v = (m > cap) ? cap : m;
    sat_dw = neg ? DATA_WIDTH'(~v + SW'(1)) : DATA_WIDTH'(v);
  endfunction

  // gain term: product magnitude >> FRAC_BITS, signed, clamped to TERM_K+1 bits
  function automatic logic signed [ACC_W-1:0] term_of(logic [PW-1:0] prod, logic neg);
    logic [TW-1:0]    ps;
    logic [TW-1:0]    cap;
    logic [ACC_W-1:0] v;
    ps  = TW'(prod >> FRAC_BITS);
    cap = neg ? (TW'(1) << TERM_K) : ((TW'(1) << TERM_K) - TW'(1));
    v   = ACC_W'((ps > cap) ? cap : ps);
    term_of = neg ? signed'(~v + ACC_W'(1)) : signed'(v);
  endfunction

endpackage

// ===== hw/rtl/pcl_mul.sv =====
// ----------------------------------------------------------------------------
// pcl_mul - shared unsigned multiplier
// One magnitude product per cycle, result registered.
// ----------------------------------------------------------------------------
module pcl_mul (
  input  logic                      clk,
  input  logic [pcl_pkg::MW-1:0]    a,
  input  logic [pcl_pkg::MW-1:0]    b,
  output logic [pcl_pkg::PW-1:0]    prod
);

  logic [pcl_pkg::PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= pcl_pkg::PW'(a) * pcl_pkg::PW'(b);
  end

  assign prod = prod_r;

endmodule

// ===== hw/rtl/pcl_div.sv =====
// ----------------------------------------------------------------------------
// pcl_div - iterative restoring divider
// Two quotient bits per cycle; done stays high until the next start.
// ----------------------------------------------------------------------------
module pcl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcl_pkg::NWP-1:0]     dividend,
  input  logic [pcl_pkg::DT_W-1:0]    divisor,
  output logic                        done,
  output logic [pcl_pkg::NWP-1:0]     quotient
);

  localparam int RW = pcl_pkg::DT_W;

  logic [pcl_pkg::NWP-1:0]   q_r;
  logic [RW-1:0]             rem_r;
  logic [RW-1:0]             d_r;
  logic [pcl_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [pcl_pkg::NWP-1:0]   q_nxt;
  logic [RW-1:0]             rem_nxt;

  // two dependent shift/compare/subtract steps
  always_comb begin
    logic [RW:0]             t;
    logic [RW-1:0]           r;
    logic [pcl_pkg::NWP-1:0] q;
    r = rem_r;
    q = q_r;
    t = '0;
    for (int i = 0; i < 2; i++) begin
      t = {r, q[pcl_pkg::NWP-1]};
      q = {q[pcl_pkg::NWP-2:0], 1'b0};
      if (t >= {1'b0, d_r}) begin
        t    = t - {1'b0, d_r};
        q[0] = 1'b1;
      end
      r = t[RW-1:0];
    end
    q_nxt   = q;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= pcl_pkg::CNT_W'(pcl_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - pcl_pkg::CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hw/rtl/pid_controller_clamped_integral.sv =====
// ----------------------------------------------------------------------------
// pid_controller_clamped_integral - fixed-point PID with clamped integral
// Each input word carries a measured value in signed Q16.16 and a time
// step in unsigned Q15.16 (31 bits). The block forms the error against
// the setpoint, the derivative (error - last error) / time_step, and adds
// error*time_step to an integral held within +/- integral_limit (200.0 after
// reset). One result word per input: drive = kp*e + ki*i + kd*d, saturated
// to 32 bits, and zero_step, set when time_step was zero (derivative forced
// to zero, nothing added to the integral). Writing the setpoint clears the
// integral and the last error; write configuration only while idle. A word
// passes the states ERR, DIFF, INTG, MUL_I, ACC_I, DIVW (waits for the
// divider), MUL_D, ACC_D and OUT (waits for a free result register);
// in_ready and out_valid rise in the same cycle. The divider (2 quotient bits
// per cycle over a 50-bit dividend) sets the pace, and the four products
// share one registered 32x32 multiplier that works alongside it. in_ready
// is high only while the sequencer is idle; the result register lets a new
// word enter while the previous result still waits for out_ready.
// ----------------------------------------------------------------------------
module pid_controller_clamped_integral (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   cfg_we,
  input  logic [pcl_pkg::IDX_W-1:0]              cfg_index,
  input  logic [pcl_pkg::CFG_W-1:0]              cfg_data,

  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [pcl_pkg::FIELD_W-1:0]     in_measured,
  input  logic [pcl_pkg::DT_W-1:0]               in_time_step,

  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pcl_pkg::FIELD_W-1:0]     out_drive,
  output logic                                   out_zero_step
);

  localparam int DW  = pcl_pkg::DATA_WIDTH;
  localparam int MW  = pcl_pkg::MW;
  localparam int EW  = MW + 1;                                   // error subtract
  localparam int LW  = ((DW > pcl_pkg::LIM_W) ? DW : pcl_pkg::LIM_W) + 2; // clamp
  localparam int OK  = ((DW < pcl_pkg::FIELD_W) ? DW : pcl_pkg::FIELD_W) - 1;
  localparam int AW  = pcl_pkg::ACC_W;

  localparam logic signed [EW-1:0] E_HI = {{(EW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [EW-1:0] E_LO = ~E_HI;
  localparam logic signed [AW-1:0] O_HI = {{(AW - OK){1'b0}}, {OK{1'b1}}};
  localparam logic signed [AW-1:0] O_LO = ~O_HI;

  // --- configuration registers -------------------------------------------
  logic signed [pcl_pkg::FIELD_W-1:0] set_r, kp_r, ki_r, kd_r;
  logic [pcl_pkg::LIM_W-1:0]          lim_r;

  // --- per-word and loop state --------------------------------------------
  pcl_pkg::pcl_state_t state_r, state_nxt;

  logic signed [pcl_pkg::FIELD_W-1:0] meas_r;
  logic [pcl_pkg::DT_W-1:0]           dt_r;
  logic signed [DW-1:0]               err_r;
  logic signed [DW-1:0]               last_r;
  logic signed [DW-1:0]               integral_r;
  logic signed [DW-1:0]               deriv_r;
  logic signed [AW-1:0]               acc_r;
  logic                               zero_r;
  logic                               diff_neg_r;

  logic signed [pcl_pkg::FIELD_W-1:0] drive_r;
  logic                               zstep_r;
  logic                               out_valid_r;

  // --- shared units --------------------------------------------------------
  logic [MW-1:0]                mul_a, mul_b;
  logic [pcl_pkg::PW-1:0]       prod;
  logic                         div_start;
  logic [pcl_pkg::NWP-1:0]      div_dividend;
  logic                         div_done;
  logic [pcl_pkg::NWP-1:0]      div_quot;

  pcl_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pcl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // --- magnitudes of signed operands ----------------------------------------
  logic [pcl_pkg::FIELD_W-1:0] kp_mag, ki_mag, kd_mag;
  logic [DW-1:0]               err_mag, int_mag, der_mag;

  assign kp_mag  = kp_r[pcl_pkg::FIELD_W-1] ? (~kp_r + 1'b1) : kp_r;
  assign ki_mag  = ki_r[pcl_pkg::FIELD_W-1] ? (~ki_r + 1'b1) : ki_r;
  assign kd_mag  = kd_r[pcl_pkg::FIELD_W-1] ? (~kd_r + 1'b1) : kd_r;
  assign err_mag = err_r[DW-1]      ? (~err_r + 1'b1)      : err_r;
  assign int_mag = integral_r[DW-1] ? (~integral_r + 1'b1) : integral_r;
  assign der_mag = deriv_r[DW-1]    ? (~deriv_r + 1'b1)    : deriv_r;

  // --- error: setpoint - measured, saturated --------------------------------
  logic signed [EW-1:0] err_wide;
  logic signed [DW-1:0] err_sat;

  assign err_wide = EW'(set_r) - EW'(meas_r);
  always_comb begin
    if (err_wide > E_HI) begin
      err_sat = DW'(E_HI);
    end else if (err_wide < E_LO) begin
      err_sat = DW'(E_LO);
    end else begin
      err_sat = DW'(err_wide);
    end
  end

  // --- derivative numerator: |err - last| << FRAC_BITS ----------------------
  logic signed [DW:0] diff;
  logic [DW:0]        diff_mag;

  assign diff         = (DW + 1)'(err_r) - (DW + 1)'(last_r);
  assign diff_mag     = diff[DW] ? (~diff + 1'b1) : diff;
  assign div_dividend = pcl_pkg::NWP'({diff_mag, {pcl_pkg::FRAC_BITS{1'b0}}});

  // --- integral update ------------------------------------------------------
  logic signed [DW-1:0] int_step;
  logic signed [DW:0]   int_sum;
  logic signed [DW-1:0] int_sat;
  logic signed [LW-1:0] int_ext, lim_ext;
  logic signed [DW-1:0] int_new;

  // |err| * dt back to Q16.16, then signed and saturated
  assign int_step = pcl_pkg::sat_dw(pcl_pkg::SW'(prod >> pcl_pkg::FRAC_BITS), err_r[DW-1]);
  assign int_sum  = (DW + 1)'(integral_r) + (DW + 1)'(int_step);

  always_comb begin
    // top two bits disagree: wrapped, pin to the rail on the sign side
    if (int_sum[DW] != int_sum[DW-1]) begin
      int_sat = int_sum[DW] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
    end else begin
      int_sat = int_sum[DW-1:0];
    end
    int_ext = LW'(int_sat);
    lim_ext = signed'(LW'(lim_r));
    if (int_ext > lim_ext) begin
      int_ext = lim_ext;
    end
    if (int_ext < -lim_ext) begin
      int_ext = -lim_ext;
    end
    int_new = DW'(int_ext);
  end

  // --- gain term from the product register ---------------------------------
  logic                 term_neg;
  logic signed [AW-1:0] term;

  always_comb begin
    unique case (state_r)
      pcl_pkg::ST_ACC_I: term_neg = ki_r[pcl_pkg::FIELD_W-1] ^ integral_r[DW-1];
      pcl_pkg::ST_ACC_D: term_neg = kd_r[pcl_pkg::FIELD_W-1] ^ deriv_r[DW-1];
      default:           term_neg = kp_r[pcl_pkg::FIELD_W-1] ^ err_r[DW-1];
    endcase
  end

  assign term = pcl_pkg::term_of(prod, term_neg);

  // --- output saturation: DATA_WIDTH then the 32 bit field -------------------
  logic signed [AW-1:0] acc_sat;

  always_comb begin
    if (acc_r > O_HI) begin
      acc_sat = O_HI;
    end else if (acc_r < O_LO) begin
      acc_sat = O_LO;
    end else begin
      acc_sat = acc_r;
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // --- sequencer --------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      pcl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = pcl_pkg::ST_ERR;
        end
      end
      pcl_pkg::ST_ERR: begin
        state_nxt = pcl_pkg::ST_DIFF;
      end
      pcl_pkg::ST_DIFF: begin
        // divider starts; multiplier forms |err| * dt
        div_start = 1'b1;
        mul_a     = MW'(err_mag);
        mul_b     = MW'(dt_r);
        state_nxt = pcl_pkg::ST_INTG;
      end
      pcl_pkg::ST_INTG: begin
        mul_a     = MW'(kp_mag);
        mul_b     = MW'(err_mag);
        state_nxt = pcl_pkg::ST_MUL_I;
      end
      pcl_pkg::ST_MUL_I: begin
        mul_a     = MW'(ki_mag);
        mul_b     = MW'(int_mag);
        state_nxt = pcl_pkg::ST_ACC_I;
      end
      pcl_pkg::ST_ACC_I: begin
        state_nxt = pcl_pkg::ST_DIVW;
      end
      pcl_pkg::ST_DIVW: begin
        if (div_done) begin
          state_nxt = pcl_pkg::ST_MUL_D;
        end
      end
      pcl_pkg::ST_MUL_D: begin
        mul_a     = MW'(kd_mag);
        mul_b     = MW'(der_mag);
        state_nxt = pcl_pkg::ST_ACC_D;
      end
      pcl_pkg::ST_ACC_D: begin
        state_nxt = pcl_pkg::ST_OUT;
      end
      pcl_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = pcl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcl_pkg::ST_IDLE;
      end
    endcase
  end

  // --- datapath registers -----------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      pcl_pkg::ST_IDLE: begin
        if (in_valid) begin
          meas_r <= in_measured;
          dt_r   <= in_time_step;
        end
      end
      pcl_pkg::ST_ERR: begin
        err_r <= err_sat;
      end
      pcl_pkg::ST_DIFF: begin
        diff_neg_r <= diff[DW];
        zero_r     <= (dt_r == '0);
      end
      pcl_pkg::ST_MUL_I: begin
        acc_r <= term;                        // kp term
      end
      pcl_pkg::ST_ACC_I: begin
        acc_r <= acc_r + term;                // ki term
      end
      pcl_pkg::ST_DIVW: begin
        if (div_done) begin
          deriv_r <= zero_r ? '0 : pcl_pkg::sat_dw(pcl_pkg::SW'(div_quot), diff_neg_r);
        end
      end
      pcl_pkg::ST_ACC_D: begin
        acc_r <= acc_r + term;                // kd term
      end
      pcl_pkg::ST_OUT: begin
        if (out_free) begin
          drive_r <= pcl_pkg::FIELD_W'(acc_sat);
          zstep_r <= zero_r;
        end
      end
      default: ;
    endcase
  end

  // --- loop state, configuration, result handshake ------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r       <= '0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      lim_r       <= pcl_pkg::LIM_RESET;
      integral_r  <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == pcl_pkg::ST_DIFF) begin
        last_r <= err_r;
      end
      if (state_r == pcl_pkg::ST_INTG) begin
        integral_r <= int_new;
      end

      if (state_r == pcl_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          pcl_pkg::REG_SETPOINT: begin
            set_r      <= cfg_data;
            integral_r <= '0;
            last_r     <= '0;
          end
          pcl_pkg::REG_GAIN_P: kp_r  <= cfg_data;
          pcl_pkg::REG_GAIN_I: ki_r  <= cfg_data;
          pcl_pkg::REG_GAIN_D: kd_r  <= cfg_data;
          pcl_pkg::REG_LIMIT:  lim_r <= cfg_data[pcl_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = drive_r;
  assign out_zero_step = zstep_r;

endmodule

// ===== tb/pid_controller_clamped_integral_test.sv =====
// ----------------------------------------------------------------------------
// pid_controller_clamped_integral_test - self-checking bench for the PID block
// A directed table (reset state, field extremes, saturation, zero time step,
// integral clamp, ignored register) is followed by random phases with random
// register settings. Results are checked against typed rows or an in-bench model.
// ----------------------------------------------------------------------------
module pid_controller_clamped_integral_test;

  // ---------------------------------------------------------------- constants
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int SETTLE_CYCLES = 40;   // margin after the last result word
  localparam int PHASE_WORDS   = 108;

  // index that maps to no register; the block must ignore the write
  localparam logic [pcl_pkg::IDX_W-1:0] REG_NONE = pcl_pkg::IDX_W'(7);

  // ---------------------------------------------------------------- types
  typedef struct packed {
    logic signed [pcl_pkg::FIELD_W-1:0] drive;
    logic                               zero_step;
  } result_t;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

  // one row of the directed table; typed rows carry their expected result
  typedef struct packed {
    row_kind_t                   kind;
    logic [pcl_pkg::IDX_W-1:0]   index;
    logic [pcl_pkg::CFG_W-1:0]   value;
    logic [pcl_pkg::FIELD_W-1:0] measured;
    logic [pcl_pkg::DT_W-1:0]    time_step;
    logic                        typed;
    logic [pcl_pkg::FIELD_W-1:0] drive;
    logic                        zero_step;
  } plan_row_t;

  localparam int PLAN_LEN = 30;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset state: all gains zero, drive must be zero
    '{ROW_WORD,  '0, 32'h0, 32'h0000_0000, 31'h0001_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h7fff_ffff, 31'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
    // full-scale proportional gain, both output rails
    '{ROW_WRITE, pcl_pkg::REG_GAIN_P, 32'h7fff_ffff, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h8000_0000, 31'h0001_0000, 1'b1, 32'h7fff_ffff, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_GAIN_P, 32'h8000_0000, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h8000_0000, 31'h7fff_ffff, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h7fff_ffff, 31'h0000_0000, 1'b1, 32'h7fff_ffff, 1'b1},
    // unity gains, tight clamp, setpoint 10.0
    '{ROW_WRITE, pcl_pkg::REG_GAIN_P, 32'h0001_0000, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_GAIN_I, 32'h0001_0000, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_GAIN_D, 32'h0001_0000, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_LIMIT,  32'h0005_0000, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_SETPOINT, 32'h000a_0000, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h0000_0000, 31'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h0002_0000, 31'h0000_8000, 1'b0, 32'h0, 1'b0},
    // smallest step: derivative hits both rails
    '{ROW_WORD,  '0, 32'h0, 32'h0000_0000, 31'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h7fff_ffff, 31'h0000_0001, 1'b0, 32'h0, 1'b0},
    // zero clamp pins the integral
    '{ROW_WRITE, pcl_pkg::REG_LIMIT,  32'h0000_0000, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'hffff_0000, 31'h0002_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_LIMIT,  32'h7fff_ffff, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_GAIN_I, 32'h7fff_ffff, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h8000_0000, 31'h7fff_ffff, 1'b0, 32'h0, 1'b0},
    // setpoint extremes, error saturates low and high
    '{ROW_WRITE, pcl_pkg::REG_SETPOINT, 32'h8000_0000, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_GAIN_D, 32'h8000_0000, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h7fff_ffff, 31'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_SETPOINT, 32'h7fff_ffff, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h8000_0000, 31'h0000_0000, 1'b0, 32'h0, 1'b0},
    // unmapped index is a no-op; limit write with bit 31 set keeps 31 bits
    '{ROW_WRITE, REG_NONE,   32'hdead_beef, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h1234_5678, 31'h0000_4000, 1'b0, 32'h0, 1'b0},
    '{ROW_WRITE, pcl_pkg::REG_LIMIT,  32'hffff_ffff, 32'h0, 31'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_WORD,  '0, 32'h0, 32'h0000_0000, 31'h0001_0000, 1'b0, 32'h0, 1'b0}
  };

  // ---------------------------------------------------------------- DUT ports
  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               cfg_we;
  logic [pcl_pkg::IDX_W-1:0]          cfg_index;
  logic [pcl_pkg::CFG_W-1:0]          cfg_data;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [pcl_pkg::FIELD_W-1:0] in_measured;
  logic [pcl_pkg::DT_W-1:0]           in_time_step;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [pcl_pkg::FIELD_W-1:0] out_drive;
  logic                               out_zero_step;

  pid_controller_clamped_integral dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_measured   (in_measured),
    .in_time_step  (in_time_step),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive     (out_drive),
    .out_zero_step (out_zero_step)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- bench state
  result_t drive_due [$];      // expected result words, oldest first
  int      fail_count    = 0;
  int      words_sent    = 0;
  int      words_checked = 0;
  int      zero_results  = 0;
  int      reg_writes    = 0;
  bit      words_since_settle = 1'b0;

  // receiver control; calm and stall_request come from the stimulus
  bit      calm          = 1'b0;  // no idling on either side
  bit      stall_request = 1'b0;  // ask receiver for the long hold-off
  bit      stall_taken   = 1'b0;
  int      hold_left     = 0;

  // ---------------------------------------------------------------- model state
  logic signed [pcl_pkg::FIELD_W-1:0]    sp_reg, kp_reg, ki_reg, kd_reg;
  logic [pcl_pkg::LIM_W-1:0]             lim_reg;
  logic signed [pcl_pkg::DATA_WIDTH-1:0] integ_acc, err_prev;

  // clamp to the two's complement range of k+1 bits
  function automatic longint clamp_signed(longint v, int k);
    longint hi;
    longint lo;
    hi = (longint'(1) << k) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // signed value from a magnitude and sign, clamped to k+1 bits
  function automatic longint from_magnitude(logic [63:0] m, bit neg, int k);
    logic [63:0] cap;
    cap = neg ? (64'd1 << k) : ((64'd1 << k) - 64'd1);
    if (m > cap) m = cap;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // (a*b) >> FRAC_BITS, truncated toward zero, clamped to k+1 bits
  function automatic longint scaled_mul(longint a, longint b, int k);
    logic [63:0] ma;
    logic [63:0] mb;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    return from_magnitude((ma * mb) >> pcl_pkg::FRAC_BITS, (a < 0) != (b < 0), k);
  endfunction

  function automatic void reset_model();
    sp_reg    = '0;
    kp_reg    = '0;
    ki_reg    = '0;
    kd_reg    = '0;
    lim_reg   = pcl_pkg::LIM_RESET;
    integ_acc = '0;
    err_prev  = '0;
  endfunction

  function automatic void model_write(logic [pcl_pkg::IDX_W-1:0] idx,
                                      logic [pcl_pkg::CFG_W-1:0] val);
    case (idx)
      pcl_pkg::REG_SETPOINT: begin
        sp_reg    = val;
        integ_acc = '0;
        err_prev  = '0;
      end
      pcl_pkg::REG_GAIN_P: kp_reg  = val;
      pcl_pkg::REG_GAIN_I: ki_reg  = val;
      pcl_pkg::REG_GAIN_D: kd_reg  = val;
      pcl_pkg::REG_LIMIT:  lim_reg = val[pcl_pkg::LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // one control update: advances integral and last error, returns the word
  function automatic result_t pid_predict(logic signed [pcl_pkg::FIELD_W-1:0] meas,
                                          logic [pcl_pkg::DT_W-1:0] dt);
    longint      err;
    longint      diff;
    longint      deriv;
    longint      acc;
    longint      sum;
    logic [63:0] dmag;
    result_t     r;
    err = clamp_signed(longint'(sp_reg) - longint'(meas), pcl_pkg::DATA_WIDTH - 1);
    if (dt == '0) begin
      deriv = 0;
    end else begin
      diff  = err - longint'(err_prev);
      dmag  = (diff < 0) ? 64'(-diff) : 64'(diff);
      deriv = from_magnitude((dmag << pcl_pkg::FRAC_BITS) / 64'(dt), diff < 0,
                             pcl_pkg::DATA_WIDTH - 1);
    end
    acc = clamp_signed(longint'(integ_acc)
                       + scaled_mul(err, longint'(dt), pcl_pkg::DATA_WIDTH - 1),
                       pcl_pkg::DATA_WIDTH - 1);
    if (acc > longint'(lim_reg))  acc = longint'(lim_reg);
    if (acc < -longint'(lim_reg)) acc = -longint'(lim_reg);
    integ_acc = pcl_pkg::DATA_WIDTH'(acc);
    err_prev  = pcl_pkg::DATA_WIDTH'(err);
    sum = scaled_mul(longint'(kp_reg), err, pcl_pkg::TERM_K)
        + scaled_mul(longint'(ki_reg), acc, pcl_pkg::TERM_K)
        + scaled_mul(longint'(kd_reg), deriv, pcl_pkg::TERM_K);
    r.drive     = pcl_pkg::FIELD_W'(clamp_signed(clamp_signed(sum, pcl_pkg::DATA_WIDTH - 1),
                                                 pcl_pkg::FIELD_W - 1));
    r.zero_step = (dt == '0);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus tasks
  // drop valid for an idle gap set by n; payload scrambles meanwhile and must be ignored
  task automatic idle_in(int n);
    @(negedge clk);
    in_valid     <= 1'b0;
    in_measured  <= $urandom;
    in_time_step <= pcl_pkg::DT_W'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic random_gap();
    if (!calm && $urandom_range(99) < 32)
      idle_in(($urandom_range(4) == 0) ? $urandom_range(5, 45) : $urandom_range(1, 4));
  endtask

  // offer one word and hold it until accepted; typed rows override the model
  task automatic send_word(logic signed [pcl_pkg::FIELD_W-1:0] meas,
                           logic [pcl_pkg::DT_W-1:0] dt,
                           bit use_typed, result_t typed_res);
    result_t want;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_measured  <= meas;
    in_time_step <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = pid_predict(meas, dt);
    if (use_typed) want = typed_res;
    drive_due.push_back(want);
    words_sent++;
    words_since_settle = 1'b1;
  endtask

  task automatic write_reg(logic [pcl_pkg::IDX_W-1:0] idx, logic [pcl_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= $urandom;
    model_write(idx, val);
    reg_writes++;
  endtask

  // let the block drain completely before touching its registers
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    words_since_settle = 1'b0;
  endtask

  // ---------------------------------------------------------------- random values
  function automatic logic [pcl_pkg::CFG_W-1:0] pick_gain();
    logic [pcl_pkg::CFG_W-1:0] v;
    case ($urandom_range(9))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = '0;
      3: v = $urandom;
      default: begin
        // realistic gains within +/- 4.0
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [pcl_pkg::CFG_W-1:0] pick_setpoint();
    logic [pcl_pkg::CFG_W-1:0] v;
    case ($urandom_range(7))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0064_0000);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [pcl_pkg::CFG_W-1:0] pick_limit();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'h7fff_ffff;
      2: return $urandom;  // bit 31 is dropped by the register
      3: return pcl_pkg::CFG_W'(pcl_pkg::LIM_RESET);
      default: return $urandom_range(1, 32'h0032_0000);
    endcase
  endfunction

  function automatic logic [pcl_pkg::FIELD_W-1:0] pick_measured();
    logic [pcl_pkg::FIELD_W-1:0] delta;
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: begin
        // close to the target, wrapping is fine
        delta = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(1)) delta = -delta;
        return sp_reg + delta;
      end
    endcase
  endfunction

  function automatic logic [pcl_pkg::DT_W-1:0] pick_step();
    case ($urandom_range(19))
      0, 1: return '0;
      2: return pcl_pkg::DT_W'(1);
      3: return {pcl_pkg::DT_W{1'b1}};
      4, 5: return pcl_pkg::DT_W'($urandom);
      default: return pcl_pkg::DT_W'($urandom_range(1, 32'h0002_0000));
    endcase
  endfunction

  // one random phase: new register settings, then a stream of words
  task automatic run_phase(int n, bit quiet, bit squeeze);
    result_t none;
    none = '0;
    settle();
    write_reg(pcl_pkg::REG_GAIN_P, pick_gain());
    write_reg(pcl_pkg::REG_GAIN_I, pick_gain());
    write_reg(pcl_pkg::REG_GAIN_D, pick_gain());
    write_reg(pcl_pkg::REG_LIMIT, pick_limit());
    // sometimes keep the setpoint so integral and last error carry over
    if ($urandom_range(2) != 0) write_reg(pcl_pkg::REG_SETPOINT, pick_setpoint());
    if ($urandom_range(3) == 0) write_reg(REG_NONE, $urandom);
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 3) stall_request = 1'b1;
      random_gap();
      send_word(pick_measured(), pick_step(), 1'b0, none);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------- main sequence
  initial begin
    result_t typed_res;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_measured  = '0;
    in_time_step = '0;
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table; a write row first waits for the block to go idle
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        if (words_since_settle) settle();
        write_reg(PLAN[r].index, PLAN[r].value);
      end else begin
        typed_res.drive     = PLAN[r].drive;
        typed_res.zero_step = PLAN[r].zero_step;
        random_gap();
        send_word(PLAN[r].measured, PLAN[r].time_step, PLAN[r].typed, typed_res);
      end
    end

    // first phase runs without idling, the third one squeezes the block
    run_phase(PHASE_WORDS, 1'b1, 1'b0);
    run_phase(PHASE_WORDS, 1'b0, 1'b0);
    run_phase(PHASE_WORDS, 1'b0, 1'b1);
    run_phase(PHASE_WORDS, 1'b0, 1'b0);
    run_phase(PHASE_WORDS, 1'b0, 1'b0);
    settle();

    $display("Covered %0d words (%0d with zero time step) over %0d register writes,",
             words_sent, zero_results, reg_writes);
    $display("%0d result words checked, one %0d-cycle output hold-off.",
             words_checked, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("pid_controller_clamped_integral_test OK");
    end else begin
      $display("pid_controller_clamped_integral_test NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // out_ready changes on the falling edge: random idling, calm stretches, and
  // one long hold-off so the result register fills and in_ready drops
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_request && !stall_taken) begin
        stall_taken = 1'b1;
        hold_left   = HOLD_CYCLES - 1;
        out_ready  <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_due.size() == 0) begin
        $error("result word with nothing expected: drive %0d zero_step %0b",
               out_drive, out_zero_step);
        fail_count++;
      end else begin
        want = drive_due.pop_front();
        if (out_drive !== want.drive) begin
          $error("drive: expected %0d, actual %0d", want.drive, out_drive);
          fail_count++;
        end
        if (out_zero_step !== want.zero_step) begin
          $error("zero_step: expected %0b, actual %0b", want.zero_step, out_zero_step);
          fail_count++;
        end
        if (want.zero_step) zero_results++;
        words_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  // several times the slowest legal run
  initial begin
    #8_000_000;
    $display("pid_controller_clamped_integral_test NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_mul.sv
hw/rtl/pcl_div.sv
hw/rtl/pid_controller_clamped_integral.sv
tb/pid_controller_clamped_integral_test.sv
